>>> rtl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared widths, register indexes and types for the life row stencil.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int ROW_W         = 64;  // row_cells / next_cells
  localparam int IDX_W         = 16;  // row_index, grid_height
  localparam int WID_W         = 7;   // grid_width
  localparam int CFG_ADDR_W    = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int OUT_DEPTH     = 4;   // result queue entries

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = CFG_ADDR_W'(1);

  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(64);
  localparam logic [IDX_W-1:0] HEIGHT_RESET = IDX_W'(64);
  localparam logic [WID_W-1:0] WIDTH_MIN    = WID_W'(3);
  localparam logic [IDX_W-1:0] HEIGHT_MIN   = IDX_W'(3);

  typedef logic [ROW_W-1:0] row_t;

  // Bits one cell shows to its neighbors: the same column of the three rows.
  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } nbr_t;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic             load;
    logic             force_full;  // first or last row: whole row is wall
    logic [WID_W-1:0] width;       // clamped width in use
  } cell_ctl_t;

  typedef struct packed {
    row_t             next_cells;
    logic [IDX_W-1:0] row_index;
    logic             frame_last;
  } out_item_t;

endpackage

>>> rtl/lgrs_row_if.sv
// ----------------------------------------------------------------------------
// lgrs_row_if
// Input row channel: valid/ready with one grid row.
// ----------------------------------------------------------------------------
interface lgrs_row_if;
  logic          valid;
  logic          ready;
  lgrs_pkg::row_t row_cells;

  modport source (output valid, output row_cells, input ready);
  modport sink   (input valid, input row_cells, output ready);
endinterface

>>> rtl/lgrs_res_if.sv
// ----------------------------------------------------------------------------
// lgrs_res_if
// Result channel: valid/ready with one next-generation row.
// ----------------------------------------------------------------------------
interface lgrs_res_if;
  logic                       valid;
  logic                       ready;
  lgrs_pkg::row_t             next_cells;
  logic [lgrs_pkg::IDX_W-1:0] row_index;
  logic                       frame_last;

  modport source (output valid, output next_cells, output row_index, output frame_last,
                  input ready);
  modport sink   (input valid, input next_cells, input row_index, input frame_last,
                  output ready);
endinterface

>>> rtl/lgrs_cfg_if.sv
// ----------------------------------------------------------------------------
// lgrs_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface lgrs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lgrs_pkg::CFG_ADDR_W-1:0] reg_index;
  logic [lgrs_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/lgrs_cell.sv
// ----------------------------------------------------------------------------
// lgrs_cell
// One grid column: holds the two buffered row bits and computes the next bit.
// ----------------------------------------------------------------------------
module lgrs_cell #(
  parameter int COL = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lgrs_pkg::cell_ctl_t ctl,
  input  logic                in_bit,
  input  lgrs_pkg::nbr_t      left,
  input  lgrs_pkg::nbr_t      right,
  output lgrs_pkg::nbr_t      self_out,
  output logic                next_bit,
  output logic                mask_bit
);

  localparam logic [lgrs_pkg::WID_W-1:0] COL_W = lgrs_pkg::WID_W'(COL);

  logic       older_r, older_nxt;
  logic       middle_r, middle_nxt;
  logic       in_use, wall, row_bit;
  logic [3:0] n;

  assign in_use  = COL_W < ctl.width;
  assign wall    = (COL_W == '0) || (COL_W == ctl.width - lgrs_pkg::WID_W'(1));
  assign row_bit = in_use & (ctl.force_full | in_bit | wall);

  assign n = 4'(left.up) + 4'(left.mid) + 4'(left.down)
           + 4'(right.up) + 4'(right.mid) + 4'(right.down)
           + 4'(older_r) + 4'(row_bit);

  assign next_bit = in_use & (wall | (n == 4'd3) | (middle_r & (n == 4'd2)));
  assign mask_bit = in_use;

  assign self_out = '{up: older_r, mid: middle_r, down: row_bit};

  assign older_nxt  = ctl.load ? middle_r : older_r;
  assign middle_nxt = ctl.load ? row_bit  : middle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= 1'b0;
      middle_r <= 1'b0;
    end else begin
      older_r  <= older_nxt;
      middle_r <= middle_nxt;
    end
  end

endmodule

>>> rtl/lgrs_out_fifo.sv
// ----------------------------------------------------------------------------
// lgrs_out_fifo
// Small result queue: up to two pushes per cycle, one pop to the port.
// ----------------------------------------------------------------------------
module lgrs_out_fifo #(
  parameter int DEPTH = lgrs_pkg::OUT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push0,
  input  lgrs_pkg::out_item_t  item0,
  input  logic                 push1,   // only together with push0
  input  lgrs_pkg::out_item_t  item1,
  output logic                 room2,
  lgrs_res_if.source           out_ch
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lgrs_pkg::out_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [PW-1:0] wr_ptr_p1;

  assign room2 = cnt_r <= CW'(DEPTH - 2);
  assign pop   = out_ch.valid & out_ch.ready;

  assign out_ch.valid      = cnt_r != '0;
  assign out_ch.next_cells = mem[rd_ptr_r].next_cells;
  assign out_ch.row_index  = mem[rd_ptr_r].row_index;
  assign out_ch.frame_last = mem[rd_ptr_r].frame_last;

  assign wr_ptr_p1  = wr_ptr_r + PW'(1);
  assign wr_ptr_nxt = wr_ptr_r + PW'(push0) + PW'(push1);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push0) + CW'(push1) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr_r] <= item0;
    if (push1) mem[wr_ptr_p1] <= item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/life_generation_row_stencil.sv
// ----------------------------------------------------------------------------
// life_generation_row_stencil
// B3/S23 generation over a walled grid, one row per request, column cells.
// ----------------------------------------------------------------------------
// Latency: a result is on out_ch the cycle after the row request that causes it,
//   behind whatever the 4-entry result queue still holds.
// Throughput: one row per cycle while the queue has room for two; a frame of H rows
//   gives H results (row 1 none, the last row two); a full queue stalls the input.
// Reset (rst_n low, synchronous): line buffers, row counter and queue cleared,
//   grid_width and grid_height back to 64.
module life_generation_row_stencil #(
  parameter int MAX_WIDTH = lgrs_pkg::MAX_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lgrs_row_if.sink   in_ch,
  lgrs_res_if.source out_ch,
  lgrs_cfg_if.sink   cfg_ch
);

  localparam int WW = lgrs_pkg::WID_W;
  localparam int IW = lgrs_pkg::IDX_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

  logic [WW-1:0] width_r, width_nxt, width_eff;
  logic [IW-1:0] height_r, height_nxt, height_eff;
  logic [IW-1:0] rows_r, rows_nxt;
  logic          accept, last, first, res0_valid, room2;
  lgrs_pkg::cell_ctl_t ctl;
  lgrs_pkg::row_t      next_vec, mask_vec;
  lgrs_pkg::nbr_t      nbr [MAX_WIDTH];
  lgrs_pkg::out_item_t res0, res1, item0;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        lgrs_pkg::REG_GRID_WIDTH:  width_nxt  = cfg_ch.wdata[WW-1:0];
        lgrs_pkg::REG_GRID_HEIGHT: height_nxt = cfg_ch.wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  assign width_eff  = (width_r < lgrs_pkg::WIDTH_MIN) ? lgrs_pkg::WIDTH_MIN :
                      (width_r > MAX_W) ? MAX_W : width_r;
  assign height_eff = (height_r < lgrs_pkg::HEIGHT_MIN) ? lgrs_pkg::HEIGHT_MIN : height_r;

  // row sequencing
  assign accept = in_ch.valid & in_ch.ready;
  assign in_ch.ready = room2;
  assign first  = rows_r == '0;
  assign last   = ({1'b0, rows_r} + (IW+1)'(1)) >= {1'b0, height_eff};
  assign res0_valid = (first & ~last) | (rows_r >= IW'(2));
  assign rows_nxt = !accept ? rows_r : (last ? '0 : rows_r + IW'(1));

  assign ctl = '{load: accept, force_full: first | last, width: width_eff};

  // column cells
  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
    lgrs_pkg::nbr_t left_n, right_n;
    if (c == 0) begin : g_l0
      assign left_n = '0;
    end else begin : g_l
      assign left_n = nbr[c-1];
    end
    if (c == MAX_WIDTH - 1) begin : g_r0
      assign right_n = '0;
    end else begin : g_r
      assign right_n = nbr[c+1];
    end
    lgrs_cell #(.COL(c)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .in_bit   (in_ch.row_cells[c]),
      .left     (left_n),
      .right    (right_n),
      .self_out (nbr[c]),
      .next_bit (next_vec[c]),
      .mask_bit (mask_vec[c])
    );
  end
  if (MAX_WIDTH < lgrs_pkg::ROW_W) begin : g_pad
    assign next_vec[lgrs_pkg::ROW_W-1:MAX_WIDTH] = '0;
    assign mask_vec[lgrs_pkg::ROW_W-1:MAX_WIDTH] = '0;
  end

  // results: row r-1 (or the top wall row), then the bottom wall row on the last request
  assign res0 = '{next_cells: first ? mask_vec : next_vec,
                  row_index:  first ? '0 : rows_r - IW'(1),
                  frame_last: 1'b0};
  assign res1 = '{next_cells: mask_vec, row_index: rows_r, frame_last: 1'b1};
  assign item0 = res0_valid ? res0 : res1;

  lgrs_out_fifo #(.DEPTH(lgrs_pkg::OUT_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push0  (accept & (res0_valid | last)),
    .item0  (item0),
    .push1  (accept & res0_valid & last),
    .item1  (res1),
    .room2  (room2),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lgrs_pkg::WIDTH_RESET;
      height_r <= lgrs_pkg::HEIGHT_RESET;
      rows_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      rows_r   <= rows_nxt;
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the walled B3/S23 row stencil. Rows are streamed frame by frame under
// many grid sizes. A local next-generation predictor keeps its own line
// buffers and row counter, and each result row is compared with it as it
// leaves the block. Both sides idle at random, and the receiver once holds off
// long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_COLS          = lgrs_pkg::MAX_WIDTH_DEF;
  localparam int REG_UNMAPPED_LO   = 2;
  localparam int REG_UNMAPPED_HI   = 255;
  localparam int SETTLE_CYCLES     = 4;
  localparam int IDLE_PCT          = 6;
  localparam int HOLD_OFF_CYCLES   = 60;
  localparam int RANDOM_ROW_TARGET = 550;

  localparam int WID_W      = lgrs_pkg::WID_W;
  localparam int IDX_W      = lgrs_pkg::IDX_W;
  localparam int ROW_W      = lgrs_pkg::ROW_W;
  localparam int CFG_ADDR_W = lgrs_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = lgrs_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst_n;

  lgrs_row_if in_ch ();
  lgrs_res_if out_ch ();
  lgrs_cfg_if cfg_ch ();

  life_generation_row_stencil dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: shadow registers, line buffers, row counter.
  logic [WID_W-1:0] width_cfg;
  logic [IDX_W-1:0] height_cfg;
  lgrs_pkg::row_t   line_up;
  lgrs_pkg::row_t   line_mid;
  logic [IDX_W-1:0] frame_row;

  lgrs_pkg::out_item_t pending_rows[$];
  lgrs_pkg::out_item_t want_row;
  int        err_count;
  int        rows_sent;
  bit        idle_en;
  bit        stall_en;
  int        hold_req;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic expect_row(input lgrs_pkg::out_item_t item);
    pending_rows = {pending_rows, item};
  endtask

  function automatic lgrs_pkg::row_t cols_mask(input int w);
    return (w >= ROW_W) ? '1 : ((lgrs_pkg::row_t'(1) << w) - lgrs_pkg::row_t'(1));
  endfunction

  // One generation of the middle line; edge columns stay walls.
  function automatic lgrs_pkg::row_t life_next_row(input lgrs_pkg::row_t up,
                                                   input lgrs_pkg::row_t mid,
                                                   input lgrs_pkg::row_t down,
                                                   input int w);
    lgrs_pkg::row_t res;
    int   n;
    res = '0;
    res[0] = 1'b1;
    res[w-1] = 1'b1;
    for (int c = 1; c + 1 < w; c++) begin
      n = 0;
      n += int'(up[c-1]);
      n += int'(up[c]);
      n += int'(up[c+1]);
      n += int'(mid[c-1]);
      n += int'(mid[c+1]);
      n += int'(down[c-1]);
      n += int'(down[c]);
      n += int'(down[c+1]);
      if (n == 3 || (mid[c] && n == 2)) res[c] = 1'b1;
    end
    return res & cols_mask(w);
  endfunction

  task automatic apply_config(input logic [CFG_ADDR_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    if (idx == lgrs_pkg::REG_GRID_WIDTH) width_cfg = data[WID_W-1:0];
    else if (idx == lgrs_pkg::REG_GRID_HEIGHT) height_cfg = data[IDX_W-1:0];
  endtask

  task automatic accept_row(input lgrs_pkg::row_t cells);
    int                  w;
    int                  h;
    int                  r;
    bit                  last;
    lgrs_pkg::row_t      mask;
    lgrs_pkg::row_t      line;
    lgrs_pkg::out_item_t item;
    w = int'(width_cfg);
    if (w < int'(lgrs_pkg::WIDTH_MIN)) w = int'(lgrs_pkg::WIDTH_MIN);
    if (w > MAX_COLS) w = MAX_COLS;
    h = int'(height_cfg);
    if (h < int'(lgrs_pkg::HEIGHT_MIN)) h = int'(lgrs_pkg::HEIGHT_MIN);
    r = int'(frame_row);
    last = (r + 1 >= h);
    mask = cols_mask(w);
    if (r == 0 || last) line = mask;
    else line = (cells & mask) | lgrs_pkg::row_t'(1) | (lgrs_pkg::row_t'(1) << (w - 1));
    if (r == 0 && !last) begin
      item = '{next_cells: mask, row_index: '0, frame_last: 1'b0};
      expect_row(item);
    end else if (r >= 2) begin
      item = '{next_cells: life_next_row(line_up, line_mid, line, w),
               row_index: IDX_W'(r - 1), frame_last: 1'b0};
      expect_row(item);
    end
    if (last) begin
      item = '{next_cells: mask, row_index: IDX_W'(r), frame_last: 1'b1};
      expect_row(item);
      frame_row = '0;
    end else begin
      frame_row = IDX_W'(r + 1);
    end
    line_up = line_mid;
    line_mid = line;
  endtask

  // Leaves valid high; rows_done() drops it once a burst is over.
  task automatic send_row(input lgrs_pkg::row_t cells);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.row_cells <= cells;
    do @(posedge clk); while (!in_ch.ready);
    accept_row(cells);
    rows_sent++;
  endtask

  task automatic rows_done();
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_config(idx, data);
  endtask

  task automatic cfg_done();
    cfg_ch.valid <= 1'b0;
  endtask

  // All results in, plus a settle wait for rows that produce none.
  task automatic wait_idle();
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic lgrs_pkg::row_t random_row();
    lgrs_pkg::row_t a;
    lgrs_pkg::row_t b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return a & b;
      1: return a | b;
      2: return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  task automatic randomize_config();
    logic [WID_W-1:0] w;
    logic [IDX_W-1:0] h;
    case ($urandom_range(19))
      0: w = WID_W'($urandom_range(2, 0));
      1: w = WID_W'($urandom_range(127, 65));
      default: w = WID_W'($urandom_range(64, 3));
    endcase
    case ($urandom_range(24))
      0: h = IDX_W'($urandom_range(2, 0));
      1, 2, 3: h = IDX_W'($urandom_range(64, 13));
      default: h = IDX_W'($urandom_range(12, 3));
    endcase
    // upper data bits of the width register are don't-care
    write_reg(lgrs_pkg::REG_GRID_WIDTH, {9'($urandom_range(511, 0)), w});
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, h);
    if ($urandom_range(9) == 0)
      write_reg(CFG_ADDR_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
                CFG_DATA_W'($urandom));
    cfg_done();
  endtask

  // Sends rows until the predictor sees the frame close; may retune mid-frame.
  task automatic run_frame(input bit retune);
    int split;
    int n;
    split = $urandom_range(6, 1);
    n = 0;
    do begin
      send_row(random_row());
      n++;
      if (retune && n == split && frame_row != 0) begin
        rows_done();
        wait_idle();
        if ($urandom_range(1))
          write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'($urandom_range(64, 3)));
        else
          write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(12, 3)));
        cfg_done();
      end
    end while (frame_row != 0);
    rows_done();
  endtask

  // Untouched registers: a full 64 x 64 frame.
  task automatic test_reset_defaults();
    run_frame(1'b0);
    wait_idle();
  endtask

  task automatic test_min_grid();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'(3));
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'(3));
    cfg_done();
    send_row('1);
    send_row('0);
    send_row(random_row());
    rows_done();
    wait_idle();
  endtask

  task automatic test_full_width();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'(64));
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'(5));
    cfg_done();
    send_row('1);
    send_row({16{4'h5}});
    send_row({16{4'hA}});
    send_row('0);
    send_row('1);
    rows_done();
    wait_idle();
  endtask

  // Out-of-range sizes clamp; writes to unmapped indexes do nothing.
  task automatic test_clamped_config();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'(0));
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'(0));
    cfg_done();
    repeat (3) send_row('1);
    rows_done();
    wait_idle();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'(127));
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'(2));
    write_reg(CFG_ADDR_W'(REG_UNMAPPED_HI), '1);
    write_reg(CFG_ADDR_W'(REG_UNMAPPED_LO), '0);
    cfg_done();
    repeat (3) send_row(random_row());
    rows_done();
    wait_idle();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, 16'hFFC2);
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'(1));
    cfg_done();
    repeat (3) send_row(random_row());
    rows_done();
    wait_idle();
  endtask

  // Tallest frame, then width and height changed while it is open; the
  // height drop lands below the current row and closes the frame.
  task automatic test_midframe_change();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'(20));
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, 16'hFFFF);
    cfg_done();
    repeat (5) send_row(random_row());
    rows_done();
    wait_idle();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'(45));
    cfg_done();
    repeat (2) send_row(random_row());
    rows_done();
    wait_idle();
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'(4));
    cfg_done();
    send_row(random_row());
    rows_done();
    wait_idle();
  endtask

  task automatic test_random_frames(input int target);
    while (rows_sent < target) begin
      wait_idle();
      randomize_config();
      run_frame($urandom_range(9) == 0);
    end
    wait_idle();
  endtask

  task automatic test_no_idle(input int count);
    int stop_at;
    stop_at = rows_sent + count;
    idle_en = 1'b0;
    stall_en = 1'b0;
    test_random_frames(stop_at);
    idle_en = 1'b1;
    stall_en = 1'b1;
  endtask

  // Receiver holds off while rows keep coming, so the result queue fills.
  task automatic test_backpressure();
    write_reg(lgrs_pkg::REG_GRID_WIDTH, CFG_DATA_W'(64));
    write_reg(lgrs_pkg::REG_GRID_HEIGHT, CFG_DATA_W'(40));
    cfg_done();
    idle_en = 1'b0;
    hold_req = HOLD_OFF_CYCLES;
    run_frame(1'b0);
    wait_idle();
    idle_en = 1'b1;
  endtask

  // Result receiver: random stalls plus an occasional long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_en && $urandom_range(99) < IDLE_PCT) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected result, row %0d", out_ch.row_index));
      end else begin
        want_row = pending_rows.pop_front();
        if (out_ch.next_cells !== want_row.next_cells)
          report_mismatch($sformatf("row %0d next_cells %h, want %h", want_row.row_index,
                                    out_ch.next_cells, want_row.next_cells));
        if (out_ch.row_index !== want_row.row_index)
          report_mismatch($sformatf("row_index %0d, want %0d", out_ch.row_index,
                                    want_row.row_index));
        if (out_ch.frame_last !== want_row.frame_last)
          report_mismatch($sformatf("row %0d frame_last %b, want %b", want_row.row_index,
                                    out_ch.frame_last, want_row.frame_last));
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    err_count = 0;
    rows_sent = 0;
    idle_en = 1'b1;
    stall_en = 1'b1;
    hold_req = 0;
    width_cfg = lgrs_pkg::WIDTH_RESET;
    height_cfg = lgrs_pkg::HEIGHT_RESET;
    line_up = '0;
    line_mid = '0;
    frame_row = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.row_cells  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= '0;
    cfg_ch.wdata     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_min_grid();
    test_full_width();
    test_clamped_config();
    test_midframe_change();
    test_random_frames(rows_sent + 150);
    test_no_idle(120);
    test_backpressure();
    test_random_frames(RANDOM_ROW_TARGET);
    wait_idle();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lgrs_pkg.sv
rtl/lgrs_row_if.sv
rtl/lgrs_res_if.sv
rtl/lgrs_cfg_if.sv
rtl/lgrs_cell.sv
rtl/lgrs_out_fifo.sv
rtl/life_generation_row_stencil.sv
dv/tb_top.sv
